@@ hw/rtl/hlue_pkg.sv @@
package hlue_pkg;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_END  = 1'b1
  } hlue_action_t;

  typedef struct packed {
    hlue_action_t action;
    logic [7:0]   text_byte;
  } hlue_in_t;

  typedef struct packed {
    logic [7:0] url_byte;
    logic       last_of_link;
    logic       discard_link;
  } hlue_out_t;

  // One result from the scanner for the output stage.
  typedef struct packed {
    logic      valid;
    hlue_out_t beat;
  } hlue_result_t;

  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_A     = 8'h61;  // 'a'
  localparam logic [7:0] CH_H     = 8'h68;  // 'h'
  localparam logic [7:0] CH_R     = 8'h72;  // 'r'
  localparam logic [7:0] CH_E     = 8'h65;  // 'e'
  localparam logic [7:0] CH_F     = 8'h66;  // 'f'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_DQ    = 8'h22;  // double quote
  localparam logic [7:0] CH_SQ    = 8'h27;  // single quote
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Letter of "href" expected at a given match position.
  function automatic logic [7:0] href_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0: ch = CH_H;
      2'd1: ch = CH_R;
      2'd2: ch = CH_E;
      default: ch = CH_F;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      r = c + CASE_GAP;
    end
    return r;
  endfunction

  function automatic logic is_c_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

@@ hw/rtl/hlue_stream_if.sv @@
interface hlue_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/html_link_url_extractor.sv @@
// Timing: a URL byte is held in the scanner until the next document beat arrives
// (the hold that lets the final byte carry its end mark); the output is registered.
// Throughput: one document beat per cycle while the skid entry is free; scanner
// state is registered and the output stage has a head entry and a skid entry.
// Reset: synchronous, active high; it clears the scanner to the '<' search and
// empties the output stage.
module html_link_url_extractor (
  input  logic          clk,
  input  logic          rst,
  hlue_stream_if.sink   doc,
  hlue_stream_if.source link
);
  import hlue_pkg::*;

  hlue_result_t result;
  logic         can_push;
  logic         accept;

  // A document beat is taken whenever the skid entry is free, so the input
  // side never waits on a combinational path from the output ready.
  assign doc.ready = can_push;
  assign accept    = doc.valid && doc.ready;

  // The scanner walks the "<a", "href", "=" and quote phases and produces at
  // most one URL beat per document beat.
  hlue_scanner u_scanner (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (doc.data),
    .result (result)
  );

  // Registered output with a skid entry, so a stalled consumer does not stop
  // the beat that is already being scanned.
  hlue_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .push     (result),
    .can_push (can_push),
    .link     (link)
  );

endmodule

@@ hw/rtl/hlue_scanner.sv @@
module hlue_scanner (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  hlue_pkg::hlue_in_t   item,
  output hlue_pkg::hlue_result_t result
);
  import hlue_pkg::*;

  typedef enum logic [2:0] {
    PH_SEEK_LT = 3'd0,
    PH_SEEN_LT = 3'd1,
    PH_HREF    = 3'd2,
    PH_EQUALS  = 3'd3,
    PH_SPACE   = 3'd4,
    PH_URL     = 3'd5
  } phase_t;

  phase_t     phase, phase_next;
  logic [1:0] href_progress, href_progress_next;
  logic       quote_is_single, quote_is_single_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;

  logic [7:0] c;
  logic [7:0] lc;
  logic [7:0] close_quote;
  phase_t     reopen;

  assign c           = item.text_byte;
  assign lc          = to_lower(c);
  assign close_quote = quote_is_single ? CH_SQ : CH_DQ;
  assign reopen      = (lc == CH_LT) ? PH_SEEN_LT : PH_SEEK_LT;

  always_comb begin
    phase_next           = phase;
    href_progress_next   = href_progress;
    quote_is_single_next = quote_is_single;
    held_byte_next       = held_byte;
    held_valid_next      = held_valid;
    result               = '0;

    if (accept) begin
      if (item.action == ACT_END) begin
        if (phase == PH_URL && held_valid) begin
          result.valid             = 1'b1;
          result.beat.url_byte     = held_byte;
          result.beat.last_of_link = 1'b1;
          result.beat.discard_link = 1'b1;
        end
        phase_next           = PH_SEEK_LT;
        href_progress_next   = '0;
        quote_is_single_next = 1'b0;
        held_byte_next       = '0;
        held_valid_next      = 1'b0;
      end else begin
        case (phase)
          PH_SEEN_LT: begin
            if (lc == CH_A) begin
              phase_next         = PH_HREF;
              href_progress_next = '0;
            end else begin
              phase_next = reopen;
            end
          end
          PH_HREF: begin
            if (lc == href_char(href_progress)) begin
              if (href_progress == 2'd3) begin
                href_progress_next = '0;
                phase_next         = PH_EQUALS;
              end else begin
                href_progress_next = href_progress + 2'd1;
              end
            end else begin
              href_progress_next = (lc == CH_H) ? 2'd1 : 2'd0;
            end
          end
          PH_EQUALS: begin
            if (c == CH_EQ) begin
              phase_next = PH_SPACE;
            end
          end
          PH_SPACE: begin
            if (is_c_space(c)) begin
              phase_next = PH_SPACE;
            end else if (c == CH_DQ || c == CH_SQ) begin
              quote_is_single_next = (c == CH_SQ);
              held_valid_next      = 1'b0;
              phase_next           = PH_URL;
            end else begin
              phase_next = reopen;
            end
          end
          PH_URL: begin
            if (held_valid) begin
              result.valid             = 1'b1;
              result.beat.url_byte     = held_byte;
              result.beat.last_of_link = (c == close_quote);
            end
            if (c == close_quote) begin
              held_valid_next = 1'b0;
              phase_next      = PH_SEEK_LT;
            end else begin
              held_byte_next  = c;
              held_valid_next = 1'b1;
            end
          end
          default: begin
            phase_next = reopen;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SEEK_LT;
      href_progress   <= '0;
      quote_is_single <= 1'b0;
      held_byte       <= '0;
      held_valid      <= 1'b0;
    end else begin
      phase           <= phase_next;
      href_progress   <= href_progress_next;
      quote_is_single <= quote_is_single_next;
      held_byte       <= held_byte_next;
      held_valid      <= held_valid_next;
    end
  end

`ifndef SYNTHESIS
  // A held URL byte only exists while inside quotes.
  a_held_only_in_url: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> phase == PH_URL)
    else $error("held byte outside a quoted URL");

  // End of document always returns the scanner to its idle search.
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    accept && item.action == ACT_END |=> phase == PH_SEEK_LT && !held_valid)
    else $error("end of document did not reset the scanner");

  // A discard mark is only produced by an end of document.
  a_discard_on_end: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.beat.discard_link |-> accept && item.action == ACT_END)
    else $error("discard mark without end of document");
`endif

endmodule

@@ hw/rtl/hlue_out_stage.sv @@
module hlue_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  hlue_pkg::hlue_result_t push,
  output logic                   can_push,
  hlue_stream_if.source          link
);
  import hlue_pkg::*;

  logic      main_valid;
  hlue_out_t main_beat;
  logic      skid_valid;
  hlue_out_t skid_beat;

  // The skid entry catches a result produced while the head beat is stalled.
  assign can_push   = !skid_valid;
  assign link.valid = main_valid;
  assign link.data  = main_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || link.ready) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push.valid;
      end
    end else if (push.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || link.ready) begin
      main_beat <= skid_valid ? skid_beat : push.beat;
    end else if (push.valid && !skid_valid) begin
      skid_beat <= push.beat;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry filled while head entry is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push.valid)
    else $error("result pushed into a full output stage");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && link.ready |=> main_valid && !skid_valid)
    else $error("skid entry did not move to the head");
`endif

endmodule
